### sv/rcl_pkg.sv
package rcl_pkg;

   localparam int MAX_ENTRIES_DEF = 256;
   localparam int FIELD_W         = 9;
   localparam int DATA_W          = 16;
   localparam int SIZE_RESET      = 256;
   localparam int GROUP_SIZE      = 16;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic load_init;
      logic shift_en;
   } cell_ctl_type;

endpackage

### sv/rcl_cell.sv
module rcl_cell #(
   parameter int INDEX = 0,
   parameter int VAL_W = 9,
   parameter int CMP_W = 10
) (
   input  logic                 clock,
   input  rcl_pkg::cell_ctl_type ctl,
   input  logic [CMP_W-1:0]     idx,
   input  logic [CMP_W-1:0]     last,
   input  logic [VAL_W-1:0]     next_val,
   input  logic [VAL_W-1:0]     picked,
   output logic [VAL_W-1:0]     val,
   output logic [VAL_W-1:0]     hit_val
);
   import rcl_pkg::*;

   localparam logic [CMP_W-1:0] MY_POS  = CMP_W'(INDEX);
   localparam logic [VAL_W-1:0] INIT_VAL = VAL_W'(INDEX + 1);

   logic [VAL_W-1:0] val_ff;
   logic [VAL_W-1:0] val_in;

   assign val     = val_ff;
   assign hit_val = (MY_POS == idx) ? val_ff : '0;

   always_comb begin
      val_in = val_ff;
      if (ctl.load_init) begin
         val_in = INIT_VAL;
      end else if (ctl.shift_en) begin
         if (MY_POS == last) begin
            val_in = picked;
         end else if ((MY_POS >= idx) && (MY_POS < last)) begin
            val_in = next_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### sv/rcl_pick_tree.sv
module rcl_pick_tree #(
   parameter int N = 256,
   parameter int W = 9,
   parameter int G = 16
) (
   input  logic                clock,
   input  logic [N-1:0][W-1:0] hit_vals,
   output logic [W-1:0]        picked
);
   import rcl_pkg::*;

   localparam int NG = (N + G - 1) / G;

   logic [NG-1:0][W-1:0] group_ff;
   logic [NG-1:0][W-1:0] group_in;

   // only the selected cell drives a nonzero value, so an or merges them
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < G; j++) begin
            if (g * G + j < N) begin
               group_in[g] = group_in[g] | hit_vals[g * G + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

   always_comb begin
      picked = '0;
      for (int g = 0; g < NG; g++) begin
         picked = picked | group_ff[g];
      end
   end

endmodule

### sv/recency_order_list_unit.sv
// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tdata[8:0] position
// rsp       out        rsp_tvalid/rsp_tready  tdata[8:0] value, tuser[0] range_error
// csr       in         csr_wr_en              csr_wr_data[8:0] active_size
//
// each item passes through three steps: capture, registered group select, then the
// active cells from the position on shift at once and the result register loads;
// a range error skips the shift. the pick tree's group register adds that step.
// a stalled result holds the block in its last step until the result is taken.
// reset and any size write restore ascending order.
module recency_order_list_unit #(
   parameter int MAX_ENTRIES = rcl_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [rcl_pkg::DATA_W-1:0] req_tdata,   // [8:0] position
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rcl_pkg::DATA_W-1:0] rsp_tdata,   // [8:0] value
   output logic                       rsp_tuser,   // [0] range_error
   input  logic                       csr_wr_en,
   input  logic [rcl_pkg::FIELD_W-1:0] csr_wr_data  // [8:0] active_size
);
   import rcl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = ((CNT_W > FIELD_W) ? CNT_W : FIELD_W) + 1;
   localparam int SIZE_INIT = (SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : SIZE_RESET;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PICK = 3'b010,
      ST_MOVE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   size_ff, size_in;
   logic [CMP_W-1:0]   idx_ff, idx_in;
   logic               err_ff, err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   size_ext;
   logic [CMP_W-1:0]   last;
   logic [CMP_W-1:0]   wr_ext;
   logic               accept;
   logic               finish;
   logic [CNT_W-1:0]   picked;
   logic [CMP_W-1:0]   picked_ext;
   cell_ctl_type       ctl;

   logic [MAX_ENTRIES-1:0][CNT_W-1:0] cell_val;
   logic [MAX_ENTRIES-1:0][CNT_W-1:0] cell_hit;

   assign pos_ext    = CMP_W'(req_tdata[FIELD_W-1:0]);
   assign size_ext   = CMP_W'(size_ff);
   assign last       = size_ext - CMP_W'(1);
   assign wr_ext     = CMP_W'(csr_wr_data);
   assign picked_ext = CMP_W'(picked);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign finish     = (state_ff == ST_MOVE) && (!rsp_valid_ff || rsp_tready);

   assign ctl.load_init = reset || csr_wr_en;
   assign ctl.shift_en  = finish && !err_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_err_ff;

   always_comb begin
      size_in = size_ff;
      if (csr_wr_en) begin
         if (wr_ext == '0) begin
            size_in = CNT_W'(1);
         end else if (wr_ext > MAX_CMP) begin
            size_in = CNT_W'(MAX_ENTRIES);
         end else begin
            size_in = CNT_W'(wr_ext);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in   = pos_ext - CMP_W'(1);
               err_in   = (pos_ext == '0) || (pos_ext > size_ext);
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = err_ff;
         rsp_value_in = err_ff ? '0 : picked_ext[FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CNT_W'(SIZE_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      err_ff       <= err_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic [CNT_W-1:0] next_val;
      if (i + 1 < MAX_ENTRIES) begin : g_mid
         assign next_val = cell_val[i + 1];
      end else begin : g_end
         assign next_val = '0;
      end

      rcl_cell #(
         .INDEX (i),
         .VAL_W (CNT_W),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .idx      (idx_ff),
         .last     (last),
         .next_val (next_val),
         .picked   (picked),
         .val      (cell_val[i]),
         .hit_val  (cell_hit[i])
      );
   end

   rcl_pick_tree #(
      .N (MAX_ENTRIES),
      .W (CNT_W),
      .G (GROUP_SIZE)
   ) u_pick (
      .clock    (clock),
      .hit_vals (cell_hit),
      .picked   (picked)
   );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rcl_pkg::*;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic               range_error;
   } fetch_result_type;

   typedef enum logic {ROW_SIZE, ROW_FETCH} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      int                 arg;
      bit                 typed;
      logic [FIELD_W-1:0] want_value;
      bit                 want_err;
   } stim_row_type;

   localparam int NUM_ROWS = 27;
   localparam int HOLD_CYCLES = 200;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [DATA_W-1:0]   req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                csr_wr_en;
   logic [FIELD_W-1:0]  csr_wr_data;

   // local copy of the list and its active size
   logic [FIELD_W-1:0]  recency_list [MAX_ENTRIES_DEF];
   int                  live_size;
   fetch_result_type    pending_results [$];

   int sender_pct;
   int stall_pct;
   int hold_requests;
   int n_fetches;
   int n_results;
   int n_range_err;
   int n_size_writes;
   int n_mismatch;

   stim_row_type directed_rows [NUM_ROWS];

   recency_order_list_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic void restore_list(input int raw_size);
      int i;
      live_size = raw_size & 'h1FF;
      if (live_size < 1) live_size = 1;
      if (live_size > MAX_ENTRIES_DEF) live_size = MAX_ENTRIES_DEF;
      for (i = 0; i < MAX_ENTRIES_DEF; i++) recency_list[i] = FIELD_W'(i + 1);
   endfunction

   function automatic fetch_result_type fetch_and_rotate(input logic [FIELD_W-1:0] pos);
      fetch_result_type   r;
      logic [FIELD_W-1:0] picked;
      int                 i;
      r.value = '0;
      r.range_error = 1'b1;
      if (pos == 0 || int'(pos) > live_size) return r;
      picked = recency_list[int'(pos) - 1];
      for (i = int'(pos) - 1; i + 1 < live_size; i++) recency_list[i] = recency_list[i + 1];
      recency_list[live_size - 1] = picked;
      r.value = picked;
      r.range_error = 1'b0;
      return r;
   endfunction

   // mostly valid positions, with the edges and raw 9-bit noise mixed in
   function automatic logic [FIELD_W-1:0] pick_position();
      int r;
      r = $urandom_range(99);
      if (r < 78) return FIELD_W'($urandom_range(live_size, 1));
      if (r < 84) return FIELD_W'(live_size);
      if (r < 87) return FIELD_W'(1);
      if (r < 91) return FIELD_W'(live_size + 1);
      if (r < 94) return '0;
      return FIELD_W'($urandom());
   endfunction

   task automatic send_position(input logic [FIELD_W-1:0] pos, input bit typed,
                                input logic [FIELD_W-1:0] want_value, input bit want_err);
      fetch_result_type predicted;
      fetch_result_type typed_result;
      while ($urandom_range(99) < sender_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {{(DATA_W - FIELD_W){1'b0}}, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = fetch_and_rotate(pos);
      typed_result.value = want_value;
      typed_result.range_error = want_err;
      pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
      n_fetches++;
   endtask

   // size writes only land once the list has gone quiet
   task automatic write_size(input int raw_size);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= FIELD_W'(raw_size);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      restore_list(raw_size);
      n_size_writes++;
   endtask

   task automatic run_phase(input int raw_size, input int gap_pct, input int hold_pct,
                            input int count, input bit long_hold);
      int k;
      write_size(raw_size);
      sender_pct = gap_pct;
      stall_pct = hold_pct;
      if (long_hold) hold_requests++;
      for (k = 0; k < count; k++) send_position(pick_position(), 1'b0, '0, 1'b0);
   endtask

   // receiver side: random stalls plus the long hold-off on request
   initial begin
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      fetch_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (rsp_tuser) n_range_err++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item: value %0d range_error %0b", $time,
                     rsp_tdata, rsp_tuser);
            n_mismatch++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== {{(DATA_W - FIELD_W){1'b0}}, want.value}) begin
               $display("%0t: value expected %0d actual %0d", $time, want.value, rsp_tdata);
               n_mismatch++;
            end
            if (rsp_tuser !== want.range_error) begin
               $display("%0t: range_error expected %0b actual %0b", $time,
                        want.range_error, rsp_tuser);
               n_mismatch++;
            end
         end
      end
   end

   initial begin
      #2400000;
      $display("timeout with %0d items outstanding", pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int i;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      sender_pct = 0;
      stall_pct = 0;
      hold_requests = 0;
      n_fetches = 0;
      n_results = 0;
      n_range_err = 0;
      n_size_writes = 0;
      n_mismatch = 0;
      restore_list(SIZE_RESET);

      directed_rows = '{
         '{ROW_FETCH,   0, 1,   0, 1},   // position zero
         '{ROW_FETCH,   1, 1,   1, 0},   // first entry after reset
         '{ROW_FETCH, 256, 0,   0, 0},   // last entry, list unchanged
         '{ROW_FETCH, 257, 1,   0, 1},   // one past the end
         '{ROW_FETCH, 511, 1,   0, 1},   // all ones
         '{ROW_FETCH, 128, 0,   0, 0},
         '{ROW_FETCH, 255, 0,   0, 0},
         '{ROW_SIZE,    0, 0,   0, 0},   // saturates to one entry
         '{ROW_FETCH,   1, 1,   1, 0},
         '{ROW_FETCH,   1, 1,   1, 0},
         '{ROW_FETCH,   2, 1,   0, 1},
         '{ROW_SIZE,  511, 0,   0, 0},   // saturates to the full list
         '{ROW_FETCH, 256, 1, 256, 0},
         '{ROW_FETCH, 257, 1,   0, 1},
         '{ROW_SIZE,    2, 0,   0, 0},
         '{ROW_FETCH,   1, 1,   1, 0},
         '{ROW_FETCH,   1, 1,   2, 0},
         '{ROW_FETCH,   2, 0,   0, 0},
         '{ROW_FETCH,   3, 1,   0, 1},
         '{ROW_SIZE,    5, 0,   0, 0},
         '{ROW_FETCH,   3, 1,   3, 0},
         '{ROW_FETCH,   5, 0,   0, 0},
         '{ROW_FETCH,   1, 0,   0, 0},
         '{ROW_FETCH,   4, 0,   0, 0},
         '{ROW_SIZE,  256, 0,   0, 0},
         '{ROW_FETCH, 170, 0,   0, 0},
         '{ROW_FETCH,  85, 0,   0, 0}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         if (directed_rows[i].kind == ROW_SIZE) begin
            write_size(directed_rows[i].arg);
         end else begin
            send_position(FIELD_W'(directed_rows[i].arg), directed_rows[i].typed,
                          directed_rows[i].want_value, directed_rows[i].want_err);
         end
      end

      run_phase(256, 0, 0, 130, 1'b0);
      run_phase(7, 62, 0, 130, 1'b0);
      run_phase(1, 0, 62, 60, 1'b0);
      run_phase($urandom_range(256, 2), 34, 34, 150, 1'b0);
      // sender keeps pushing while the receiver holds off
      run_phase(300, 0, 0, 150, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d fetches, %0d results (%0d out of range), %0d size writes",
               n_fetches, n_results, n_range_err, n_size_writes);
      $display("sizes 1..256 incl. saturation, sender gaps, receiver stalls, long hold-off");
      if (n_mismatch == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
